### sv/fip_pkg.sv
// Shared types, codes and binary64 constants for the integer power core.
// Depends on nothing; used by fip_fpu and float_integer_power_core.
package fip_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned SIG_W  = 53;
	localparam int unsigned MANT_W = 106;
	localparam int unsigned EXP_W  = 13;
	localparam int unsigned CNT_W  = 7;

	localparam logic [WORD_W-1:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
	localparam logic [WORD_W-1:0] DEF_NAN     = 64'hFFF8_0000_0000_0000;
	localparam logic [WORD_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [WORD_W-1:0] EXP_MIN_INT = 64'h8000_0000_0000_0000;
	localparam logic [10:0]       EXP_ALL1    = 11'h7FF;

	typedef logic signed [EXP_W-1:0] exp_t;

	typedef enum logic {
		OP_MUL,
		OP_RECIP
	} fpu_op_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PROD,
		F_SUM,
		F_DNORM,
		F_DIV,
		F_NORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_RECIP,
		T_CHECK,
		T_MUL,
		T_SQR,
		T_OUT
	} top_state_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_ctl_t;

	function automatic logic [MANT_W-1:0] place_prod(input logic [53:0] p,
			input logic [1:0] pos);
		logic [MANT_W-1:0] r;
		unique case (pos)
			2'd0:    r = {52'b0, p};
			2'd1:    r = {25'b0, p, 27'b0};
			2'd2:    r = {p[51:0], 54'b0};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/float_integer_power_core.sv
// Binary64 base raised to a signed 64-bit integer power by square-and-multiply.
// Up to two multiplies per exponent bit, plus a reciprocal of the base when the
// exponent is negative.
// One word at a time: in_stall stays high until the result is in the output register.
// Throughput is set by the single shared multiply/divide/round unit.
// Reset clears the sequencer and output valid; payload registers are not reset.
module float_integer_power_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fip_pkg::WORD_W-1:0] base_bits,
	input  logic signed [fip_pkg::WORD_W-1:0] exponent,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [fip_pkg::WORD_W-1:0] power_bits
);
	import fip_pkg::*;

	top_state_t state_q, state_d;

	logic [WORD_W-1:0] acc_q, b_q, out_q;
	logic [62:0]       n_q;
	logic              min_q, busy_q, out_valid_q;
	fpu_ctl_t          ctl;
	logic              fpu_done;
	logic [WORD_W-1:0] fpu_res, fpu_a;
	logic              in_acc, compute;

	assign in_acc  = in_valid && !in_stall;
	assign compute = (state_q == T_RECIP) || (state_q == T_MUL) || (state_q == T_SQR);

	always_comb begin
		ctl.start = compute && !busy_q;
		ctl.op    = (state_q == T_RECIP) ? OP_RECIP : OP_MUL;
		fpu_a     = (state_q == T_MUL) ? acc_q : b_q;
	end

	fip_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a      (fpu_a),
		.b      (b_q),
		.done   (fpu_done),
		.res    (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.start)
				busy_q <= 1'b1;
			else if (fpu_done)
				busy_q <= 1'b0;
			if (state_q == T_OUT && !(out_valid_q && out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (in_acc)
					state_d = exponent[63] ? T_RECIP : T_CHECK;
			end
			T_RECIP: if (fpu_done) state_d = T_CHECK;
			T_CHECK: begin
				priority if (n_q == '0)
					state_d = T_OUT;
				else if (n_q[0])
					state_d = T_MUL;
				else
					state_d = T_SQR;
			end
			T_MUL: begin
				if (fpu_done)
					state_d = (n_q == 63'd1) ? T_CHECK : T_SQR;
			end
			T_SQR: if (fpu_done) state_d = T_CHECK;
			T_OUT: if (!(out_valid_q && out_stall)) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				b_q   <= base_bits;
				acc_q <= ONE_BITS;
				min_q <= (exponent == EXP_MIN_INT);
				if (!exponent[63])
					n_q <= exponent[62:0];
				else if (exponent == EXP_MIN_INT)
					n_q <= '1;
				else
					n_q <= 63'(-exponent);
			end
			T_RECIP: begin
				if (fpu_done) begin
					b_q <= fpu_res;
					if (min_q)
						acc_q <= fpu_res;
				end
			end
			T_MUL: begin
				if (fpu_done) begin
					acc_q <= fpu_res;
					if (n_q == 63'd1)
						n_q <= '0;
				end
			end
			T_SQR: begin
				if (fpu_done) begin
					b_q <= fpu_res;
					n_q <= {1'b0, n_q[62:1]};
				end
			end
			T_OUT: begin
				if (!(out_valid_q && out_stall))
					out_q <= acc_q;
			end
			default: ;
		endcase
	end

	assign in_stall   = (state_q != T_IDLE);
	assign out_valid  = out_valid_q;
	assign power_bits = out_q;

`ifndef SYNTH
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_done |-> busy_q && compute)
		else $error("fpu done outside a compute step");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == T_OUT)
		else $error("output valid raised outside output step");

	a_sqr_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_SQR && fpu_done) |=> n_q == {1'b0, $past(n_q[62:1])})
		else $error("exponent not shifted after square");
`endif

endmodule

### sv/fip_fpu.sv
// Iterative binary64 unit: multiply on a shared 27x27 multiplier, reciprocal by
// restoring division, then bit-serial normalize and round to nearest even.
// Depends on fip_pkg.
module fip_fpu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fip_pkg::fpu_ctl_t          ctl,
	input  logic [fip_pkg::WORD_W-1:0] a,
	input  logic [fip_pkg::WORD_W-1:0] b,
	output logic                       done,
	output logic [fip_pkg::WORD_W-1:0] res
);
	import fip_pkg::*;

	fpu_state_t state_q, state_d;

	logic [SIG_W-1:0]  sa_q, sb_q;
	logic [MANT_W-1:0] m_q;
	logic [53:0]       rem_q;
	exp_t              e_q;
	logic              sgn_q, stk_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [53:0]       prod_s1;
	logic [1:0]        pos_s1;
	logic [WORD_W-1:0] res_q;

	logic [10:0]       ea, eb;
	logic [SIG_W-1:0]  siga, sigb;
	logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [26:0]       mx, my;
	logic [1:0]        mpos;
	logic [53:0]       rem_sub;
	logic              rem_ge;
	logic [10:0]       expf;
	logic              guard, sticky, rup;

	always_comb begin
		ea     = a[62:52];
		eb     = b[62:52];
		siga   = {ea != 11'd0, a[51:0]};
		sigb   = {eb != 11'd0, b[51:0]};
		a_nan  = (ea == EXP_ALL1) && (a[51:0] != '0);
		b_nan  = (eb == EXP_ALL1) && (b[51:0] != '0);
		a_inf  = (ea == EXP_ALL1) && (a[51:0] == '0);
		b_inf  = (eb == EXP_ALL1) && (b[51:0] == '0);
		a_zero = (a[62:0] == '0);
		b_zero = (b[62:0] == '0);
	end

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				mx = sa_q[26:0];
				my = sb_q[26:0];
				mpos = 2'd0;
			end
			2'd1: begin
				mx = {1'b0, sa_q[52:27]};
				my = sb_q[26:0];
				mpos = 2'd1;
			end
			2'd2: begin
				mx = sa_q[26:0];
				my = {1'b0, sb_q[52:27]};
				mpos = 2'd1;
			end
			default: begin
				mx = {1'b0, sa_q[52:27]};
				my = {1'b0, sb_q[52:27]};
				mpos = 2'd2;
			end
		endcase
	end

	always_comb begin
		rem_ge  = rem_q >= {1'b0, sb_q};
		rem_sub = rem_ge ? (rem_q - {1'b0, sb_q}) : rem_q;
		expf    = m_q[105] ? e_q[10:0] : 11'd0;
		guard   = m_q[52];
		sticky  = stk_q | (|m_q[51:0]);
		rup     = guard & (sticky | m_q[53]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (ctl.start) begin
					if (ctl.op == OP_MUL) begin
						if (a_nan || b_nan || a_inf || b_inf || a_zero || b_zero)
							state_d = F_DONE;
						else
							state_d = F_PROD;
					end else begin
						if (b_nan || b_inf || b_zero)
							state_d = F_DONE;
						else
							state_d = F_DNORM;
					end
				end
			end
			F_PROD:  if (cnt_q[1:0] == 2'd3) state_d = F_SUM;
			F_SUM:   state_d = F_NORM;
			F_DNORM: if (sb_q[52]) state_d = F_DIV;
			F_DIV:   if (cnt_q == CNT_W'(MANT_W - 1)) state_d = F_NORM;
			F_NORM: begin
				if (!(e_q < 1) && !(!m_q[105] && e_q > 1))
					state_d = F_ROUND;
			end
			F_ROUND: state_d = F_DONE;
			F_DONE:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mx * my;
		pos_s1  <= mpos;
		unique case (state_q)
			F_IDLE: begin
				cnt_q <= '0;
				stk_q <= 1'b0;
				m_q   <= '0;
				if (ctl.op == OP_MUL) begin
					sgn_q <= a[63] ^ b[63];
					sa_q  <= siga;
					sb_q  <= sigb;
					e_q   <= exp_t'({2'b0, (ea == 11'd0) ? 11'd1 : ea})
						+ exp_t'({2'b0, (eb == 11'd0) ? 11'd1 : eb}) - exp_t'(1022);
					priority if (a_nan)
						res_q <= a | QUIET_BIT;
					else if (b_nan)
						res_q <= b | QUIET_BIT;
					else if ((a_inf && b_zero) || (a_zero && b_inf))
						res_q <= DEF_NAN;
					else if (a_inf || b_inf)
						res_q <= {a[63] ^ b[63], EXP_ALL1, 52'b0};
					else
						res_q <= {a[63] ^ b[63], 63'b0};
				end else begin
					sgn_q <= b[63];
					sb_q  <= sigb;
					e_q   <= exp_t'({2'b0, (eb == 11'd0) ? 11'd1 : eb});
					rem_q <= 54'(1) << 52;
					priority if (b_nan)
						res_q <= b | QUIET_BIT;
					else if (b_inf)
						res_q <= {b[63], 63'b0};
					else
						res_q <= {b[63], EXP_ALL1, 52'b0};
				end
			end
			F_PROD: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q[1:0] != 2'd0)
					m_q <= m_q + place_prod(prod_s1, pos_s1);
			end
			F_SUM: m_q <= m_q + place_prod(prod_s1, pos_s1);
			F_DNORM: begin
				if (sb_q[52]) begin
					e_q <= exp_t'(2046) - e_q;
				end else begin
					sb_q <= {sb_q[51:0], 1'b0};
					e_q  <= e_q - exp_t'(1);
				end
			end
			F_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				m_q   <= {m_q[MANT_W-2:0], rem_ge};
				rem_q <= {rem_sub[52:0], 1'b0};
				stk_q <= rem_sub != '0;
			end
			F_NORM: begin
				priority if (e_q < -exp_t'(108)) begin
					stk_q <= stk_q | (|m_q);
					m_q   <= '0;
					e_q   <= exp_t'(1);
				end else if (e_q < 1) begin
					stk_q <= stk_q | m_q[0];
					m_q   <= {1'b0, m_q[MANT_W-1:1]};
					e_q   <= e_q + exp_t'(1);
				end else if (!m_q[105] && e_q > 1) begin
					m_q <= {m_q[MANT_W-2:0], 1'b0};
					e_q <= e_q - exp_t'(1);
				end
			end
			F_ROUND: begin
				if (e_q > exp_t'(2046))
					res_q <= {sgn_q, EXP_ALL1, 52'b0};
				else
					res_q <= {sgn_q, {expf, m_q[104:53]} + 63'(rup)};
			end
			F_DONE: ;
			default: ;
		endcase
	end

	assign done = (state_q == F_DONE);
	assign res  = res_q;

endmodule
